// ===== hw/rtl/array_stack_with_flip_core_assert.svh =====
// Assertion macros used by the checker in asf_checker.sv.
`ifndef ARRAY_STACK_WITH_FLIP_CORE_ASSERT_SVH
`define ARRAY_STACK_WITH_FLIP_CORE_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define ASF_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Check a property on every clock edge, reset included.
`define ASF_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

// ===== hw/rtl/asf_pkg.sv =====
package asf_pkg;

   localparam int DEF_STACK_DEPTH = 64;
   localparam int DEF_DATA_WIDTH  = 32;

   localparam int OP_W     = 3;
   localparam int VALUE_W  = 32;
   localparam int INDEX_W  = 7;
   localparam int COUNT_W  = 7;
   localparam int STATUS_W = 2;

   localparam logic [OP_W-1:0] OP_PUSH  = 3'd0;
   localparam logic [OP_W-1:0] OP_POP   = 3'd1;
   localparam logic [OP_W-1:0] OP_TOP   = 3'd2;
   localparam logic [OP_W-1:0] OP_ELEM  = 3'd3;
   localparam logic [OP_W-1:0] OP_FLIP  = 3'd4;
   localparam logic [OP_W-1:0] OP_CLEAR = 3'd5;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OVER  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_UNDER = 2'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

endpackage

// ===== hw/rtl/array_stack_with_flip_core.sv =====
// channel | direction | fields
// req     | in        | operation, value, index
// rsp     | out       | data, count, empty_res, status
//
// Push, pop, top and element read access memory at accept; these, clear and
// unused codes then load the result register in S_EXEC. Flip of two or more
// words reads the low word at accept, then runs S_FRD_HI, S_FWR_LO, S_FWR_HI
// per pair: two reads and two writes through one read and one write port.
// Synchronous reset clears the height, sequencer and result valid, not the words.
// A stalled result holds the sequencer; the next item waits until it is loaded.
module array_stack_with_flip_core
   import asf_pkg::*;
#(
   parameter int STACK_DEPTH = DEF_STACK_DEPTH,
   parameter int DATA_WIDTH  = DEF_DATA_WIDTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [OP_W-1:0]     req_operation,
   input  logic [VALUE_W-1:0]  req_value,
   input  logic [INDEX_W-1:0]  req_index,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [VALUE_W-1:0]  rsp_data,
   output logic [COUNT_W-1:0]  rsp_count,
   output logic                rsp_empty_res,
   output logic [STATUS_W-1:0] rsp_status
);

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int HW = $clog2(STACK_DEPTH + 1);
   localparam int CW = (HW > INDEX_W) ? HW : INDEX_W;
   localparam int XW = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_FRD_HI,
      S_FWR_LO,
      S_FWR_HI
   } state_type;

   state_type state_ff, state_in;

   logic [DATA_WIDTH-1:0] mem_ff [STACK_DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;
   logic [DATA_WIDTH-1:0] tmp_ff, tmp_in;
   logic [HW-1:0]         height_ff, height_in;
   logic [AW-1:0]         lo_ff, lo_in;
   logic [AW-1:0]         hi_ff, hi_in;
   logic [STATUS_W-1:0]   pend_status_ff, pend_status_in;
   logic                  pend_rd_ff, pend_rd_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]    rsp_data_ff, rsp_data_in;
   logic [COUNT_W-1:0]    rsp_count_ff, rsp_count_in;
   logic                  rsp_empty_ff, rsp_empty_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;

   logic                  mem_we, mem_re;
   logic [AW-1:0]         mem_waddr, mem_raddr;
   logic [DATA_WIDTH-1:0] mem_wdata;

   logic [HW-1:0]         height_m1;
   logic [CW-1:0]         height_x, idx_x, idx_m1;
   logic [XW-1:0]         value_x, rd_x;
   logic [AW:0]           gap;

   assign height_m1 = height_ff - HW'(1);
   assign height_x  = CW'(height_ff);
   assign idx_x     = CW'(req_index);
   assign idx_m1    = idx_x - CW'(1);
   assign value_x   = XW'(req_value);
   assign rd_x      = XW'(rd_data_ff);
   assign gap       = {1'b0, hi_ff} - {1'b0, lo_ff};

   assign req_ready     = (state_ff == S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_data_ff;
   assign rsp_count     = rsp_count_ff;
   assign rsp_empty_res = rsp_empty_ff;
   assign rsp_status    = rsp_status_ff;

   always_comb begin
      state_in       = state_ff;
      tmp_in         = tmp_ff;
      height_in      = height_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      pend_status_in = pend_status_ff;
      pend_rd_in     = pend_rd_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_data_in    = rsp_data_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_empty_in   = rsp_empty_ff;
      rsp_status_in  = rsp_status_ff;
      mem_we         = 1'b0;
      mem_re         = 1'b0;
      mem_waddr      = '0;
      mem_raddr      = '0;
      mem_wdata      = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               pend_status_in = ST_OK;
               pend_rd_in     = 1'b0;
               state_in       = S_EXEC;
               unique case (req_operation)
                  OP_PUSH: begin
                     if (height_x < CW'(STACK_DEPTH)) begin
                        mem_we    = 1'b1;
                        mem_waddr = height_ff[AW-1:0];
                        mem_wdata = value_x[DATA_WIDTH-1:0];
                        height_in = height_ff + HW'(1);
                     end else begin
                        pend_status_in = ST_OVER;
                     end
                  end
                  OP_POP: begin
                     if (height_ff != '0) begin
                        mem_re     = 1'b1;
                        mem_raddr  = height_m1[AW-1:0];
                        height_in  = height_m1;
                        pend_rd_in = 1'b1;
                     end else begin
                        pend_status_in = ST_UNDER;
                     end
                  end
                  OP_TOP: begin
                     if (height_ff != '0) begin
                        mem_re     = 1'b1;
                        mem_raddr  = height_m1[AW-1:0];
                        pend_rd_in = 1'b1;
                     end else begin
                        pend_status_in = ST_UNDER;
                     end
                  end
                  OP_ELEM: begin
                     if (idx_x != '0 && idx_x <= height_x) begin
                        mem_re     = 1'b1;
                        mem_raddr  = idx_m1[AW-1:0];
                        pend_rd_in = 1'b1;
                     end else begin
                        pend_status_in = ST_RANGE;
                     end
                  end
                  OP_FLIP: begin
                     if (height_x >= CW'(2)) begin
                        mem_re    = 1'b1;
                        mem_raddr = '0;
                        lo_in     = '0;
                        hi_in     = height_m1[AW-1:0];
                        state_in  = S_FRD_HI;
                     end
                  end
                  OP_CLEAR: begin
                     height_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_FRD_HI: begin
            mem_re    = 1'b1;
            mem_raddr = hi_ff;
            tmp_in    = rd_data_ff;
            state_in  = S_FWR_LO;
         end
         S_FWR_LO: begin
            mem_we    = 1'b1;
            mem_waddr = lo_ff;
            mem_wdata = rd_data_ff;
            state_in  = S_FWR_HI;
         end
         S_FWR_HI: begin
            mem_we    = 1'b1;
            mem_waddr = hi_ff;
            mem_wdata = tmp_ff;
            if (gap > (AW + 1)'(2)) begin
               mem_re    = 1'b1;
               mem_raddr = lo_ff + AW'(1);
               lo_in     = lo_ff + AW'(1);
               hi_in     = hi_ff - AW'(1);
               state_in  = S_FRD_HI;
            end else begin
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = pend_rd_ff ? rd_x[VALUE_W-1:0] : '0;
               rsp_count_in  = height_x[COUNT_W-1:0];
               rsp_empty_in  = (height_ff == '0);
               rsp_status_in = pend_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         height_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         height_ff    <= height_in;
      end
      tmp_ff         <= tmp_in;
      lo_ff          <= lo_in;
      hi_ff          <= hi_in;
      pend_status_ff <= pend_status_in;
      pend_rd_ff     <= pend_rd_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_empty_ff   <= rsp_empty_in;
      rsp_status_ff  <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem_ff[mem_raddr];
      end
   end

endmodule

// ===== hw/rtl/asf_checker.sv =====
`include "array_stack_with_flip_core_assert.svh"

module asf_checker
   import asf_pkg::*;
#(
   parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
   input logic                clock,
   input logic                reset,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [VALUE_W-1:0]  rsp_data,
   input logic [COUNT_W-1:0]  rsp_count,
   input logic                rsp_empty_res,
   input logic [STATUS_W-1:0] rsp_status
);

   localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(STACK_DEPTH);

   logic                              rsp_stall;
   logic                              over_rsp;
   logic [VALUE_W+COUNT_W+STATUS_W:0] rsp_word;

   assign rsp_stall = rsp_valid && !rsp_ready;
   assign over_rsp  = rsp_valid && (rsp_status == ST_OVER);
   assign rsp_word  = {rsp_data, rsp_count, rsp_empty_res, rsp_status};

   `ASF_ASSERT(a_rsp_hold, clock, reset, (rsp_stall |=> rsp_valid && $stable(rsp_word)))
   `ASF_ASSERT(a_empty_flag, clock, reset, (rsp_valid |-> rsp_empty_res == (rsp_count == '0)))
   `ASF_ASSERT(a_error_data, clock, reset, (rsp_valid && rsp_status != ST_OK |-> rsp_data == '0))
   `ASF_ASSERT(a_over_full, clock, reset, (over_rsp |-> rsp_count == FULL_COUNT))
   `ASF_ASSERT_ALWAYS(a_reset_idle, clock, (reset |=> !rsp_valid && req_ready))

endmodule

bind array_stack_with_flip_core asf_checker #(.STACK_DEPTH(STACK_DEPTH)) u_asf_checker (.*);

// ===== bench/asf_stack_check.sv =====
module asf_stack_check
   import asf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic [OP_W-1:0]     req_operation,
   input  logic [VALUE_W-1:0]  req_value,
   input  logic [INDEX_W-1:0]  req_index,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic [VALUE_W-1:0]  rsp_data,
   input  logic [COUNT_W-1:0]  rsp_count,
   input  logic                rsp_empty_res,
   input  logic [STATUS_W-1:0] rsp_status,
   output int unsigned         mismatches,
   output int unsigned         outstanding,
   output int unsigned         stack_level,
   output int unsigned         results_checked,
   output int unsigned         overflow_hits,
   output int unsigned         underflow_hits,
   output int unsigned         range_hits,
   output int unsigned         peak_level
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PAW = $clog2(DEF_STACK_DEPTH);

   typedef struct packed {
      logic [VALUE_W-1:0]  data;
      logic [COUNT_W-1:0]  count;
      logic                empty_res;
      logic [STATUS_W-1:0] status;
   } stack_result_type;

   logic [VALUE_W-1:0] words [DEF_STACK_DEPTH];
   int unsigned        height;
   stack_result_type   expected_q [$];

   function automatic stack_result_type apply_op(input logic [OP_W-1:0] op,
                                                 input logic [VALUE_W-1:0] value,
                                                 input logic [INDEX_W-1:0] index);
      stack_result_type   r;
      logic [VALUE_W-1:0] held;
      int unsigned        lo;
      int unsigned        hi;
      r = '0;
      r.status = ST_OK;
      case (op)
         OP_PUSH: begin
            if (height < DEF_STACK_DEPTH) begin
               words[PAW'(height)] = value;
               height++;
            end else begin
               r.status = ST_OVER;
            end
         end
         OP_POP: begin
            if (height > 0) begin
               height--;
               r.data = words[PAW'(height)];
            end else begin
               r.status = ST_UNDER;
            end
         end
         OP_TOP: begin
            if (height > 0) begin
               r.data = words[PAW'(height - 1)];
            end else begin
               r.status = ST_UNDER;
            end
         end
         OP_ELEM: begin
            if (index >= 1 && index <= height) begin
               r.data = words[PAW'(index - 1)];
            end else begin
               r.status = ST_RANGE;
            end
         end
         OP_FLIP: begin
            if (height >= 2) begin
               lo = 0;
               hi = height - 1;
               while (lo < hi) begin
                  held = words[PAW'(lo)];
                  words[PAW'(lo)] = words[PAW'(hi)];
                  words[PAW'(hi)] = held;
                  lo++;
                  hi--;
               end
            end
         end
         OP_CLEAR: begin
            height = 0;
         end
         default: begin
         end
      endcase
      r.count = height[COUNT_W-1:0];
      r.empty_res = (height == 0);
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want_v,
                              input logic [31:0] got_v);
      if (want_v !== got_v) begin
         mismatches++;
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want_v, got_v);
      end
   endtask

   always @(posedge clock) begin : monitor
      stack_result_type want;
      stack_result_type fresh;
      if (reset) begin
         expected_q.delete();
         height = 0;
         mismatches = 0;
         results_checked = 0;
         overflow_hits = 0;
         underflow_hits = 0;
         range_hits = 0;
         peak_level = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected item: expected none, actual data=%0h count=%0d",
                        $time, rsp_data, rsp_count);
               $display("%0t: unexpected item: actual empty=%0b status=%0d",
                        $time, rsp_empty_res, rsp_status);
            end else begin
               want = expected_q.pop_front();
               results_checked++;
               check_field("data", want.data, rsp_data);
               check_field("count", 32'(want.count), 32'(rsp_count));
               check_field("empty_res", 32'(want.empty_res), 32'(rsp_empty_res));
               check_field("status", 32'(want.status), 32'(rsp_status));
            end
         end
         if (req_valid && req_ready) begin
            fresh = apply_op(req_operation, req_value, req_index);
            expected_q.push_back(fresh);
            case (fresh.status)
               ST_OVER:  overflow_hits++;
               ST_UNDER: underflow_hits++;
               ST_RANGE: range_hits++;
               default: begin
               end
            endcase
            if (height > peak_level) begin
               peak_level = height;
            end
         end
      end
      outstanding <= expected_q.size();
      stack_level <= height;
   end

endmodule

// ===== bench/tb_top.sv =====
module tb_top
   import asf_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;
   localparam int RANDOM_ITEMS    = 1280;
   localparam int QUIET_ITEMS     = 150;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int HOLD_OFF_AT     = 400;
   localparam int PAUSE_AT        = 800;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int DRAIN_CYCLES    = 120;

   typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIX, MODE_READS} traffic_mode_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [OP_W-1:0]     req_operation = OP_PUSH;
   logic [VALUE_W-1:0]  req_value = '0;
   logic [INDEX_W-1:0]  req_index = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [VALUE_W-1:0]  rsp_data;
   logic [COUNT_W-1:0]  rsp_count;
   logic                rsp_empty_res;
   logic [STATUS_W-1:0] rsp_status;

   int unsigned mismatches;
   int unsigned outstanding;
   int unsigned stack_level;
   int unsigned results_checked;
   int unsigned overflow_hits;
   int unsigned underflow_hits;
   int unsigned range_hits;
   int unsigned peak_level;

   int  items_sent = 0;
   int  src_gap_pct = 10;
   bit  idling_on = 1'b1;
   bit  hold_off_req = 1'b0;

   always #5 clock = ~clock;

   array_stack_with_flip_core DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_value     (req_value),
      .req_index     (req_index),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .rsp_count     (rsp_count),
      .rsp_empty_res (rsp_empty_res),
      .rsp_status    (rsp_status)
   );

   asf_stack_check u_stack_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_value       (req_value),
      .req_index       (req_index),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .rsp_count       (rsp_count),
      .rsp_empty_res   (rsp_empty_res),
      .rsp_status      (rsp_status),
      .mismatches      (mismatches),
      .outstanding     (outstanding),
      .stack_level     (stack_level),
      .results_checked (results_checked),
      .overflow_hits   (overflow_hits),
      .underflow_hits  (underflow_hits),
      .range_hits      (range_hits),
      .peak_level      (peak_level)
   );

   task automatic send_item(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value,
                            input logic [INDEX_W-1:0] index);
      int gap;
      if (idling_on && $urandom_range(0, 99) < src_gap_pct) begin
         gap = $urandom_range(1, 5);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_value <= value;
      req_index <= index;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   function automatic logic [OP_W-1:0] pick_op(input traffic_mode_type mode);
      int roll;
      roll = $urandom_range(0, 99);
      case (mode)
         MODE_FILL: return OP_PUSH;
         MODE_DRAIN: begin
            if (roll < 60) return OP_POP;
            if (roll < 75) return OP_TOP;
            if (roll < 85) return OP_ELEM;
            if (roll < 95) return OP_PUSH;
            return OP_FLIP;
         end
         MODE_READS: begin
            if (roll < 50) return OP_ELEM;
            if (roll < 60) return OP_TOP;
            if (roll < 75) return OP_FLIP;
            if (roll < 95) return OP_PUSH;
            return OP_POP;
         end
         default: begin
            if (roll < 35) return OP_PUSH;
            if (roll < 55) return OP_POP;
            if (roll < 65) return OP_TOP;
            if (roll < 80) return OP_ELEM;
            if (roll < 90) return OP_FLIP;
            if (roll < 94) return OP_CLEAR;
            if (roll < 97) return OP_SPARE6;
            return OP_SPARE7;
         end
      endcase
   endfunction

   function automatic logic [INDEX_W-1:0] pick_index(input int unsigned level);
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 8) return INDEX_W'($urandom_range(1, (level > 0) ? level : 1));
      if (roll == 8) return $urandom_range(0, 1) ? '0 : INDEX_W'(level + 1);
      return INDEX_W'($urandom_range(0, 127));
   endfunction

   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return VALUE_W'(1) << $urandom_range(0, VALUE_W - 1);
         default: return VALUE_W'($urandom);
      endcase
   endfunction

   initial begin : sink
      int stall_left;
      int stall_pct;
      stall_left = 0;
      stall_pct = 10;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            stall_left = HOLD_OFF_CYCLES;
         end else if (stall_left == 0 && idling_on && $urandom_range(0, 99) < stall_pct) begin
            stall_left = $urandom_range(1, 5);
         end
         if ($urandom_range(0, 63) == 0) begin
            case ($urandom_range(0, 2))
               0: stall_pct = 0;
               1: stall_pct = 10;
               default: stall_pct = 30;
            endcase
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("%0t: no item moved for %0d cycles, %0d results still due",
               $time, WATCHDOG_LIMIT, outstanding);
      $display("[array_stack_with_flip_core] ERROR");
      $finish;
   end

   initial begin : stimulus
      traffic_mode_type  mode;
      int                seg_left;
      logic [OP_W-1:0]   op;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_item(OP_POP, '0, '0);
      send_item(OP_TOP, '0, '0);
      send_item(OP_ELEM, '0, 7'd1);
      send_item(OP_ELEM, '0, 7'd0);
      send_item(OP_FLIP, '0, '0);
      send_item(OP_CLEAR, '0, '0);
      send_item(OP_PUSH, '1, '1);
      send_item(OP_FLIP, '0, '0);
      send_item(OP_TOP, '0, '0);
      send_item(OP_PUSH, '0, '0);
      send_item(OP_PUSH, 32'h8000_0001, '0);
      send_item(OP_FLIP, '0, '0);
      send_item(OP_ELEM, '0, 7'd0);
      send_item(OP_ELEM, '0, 7'd1);
      send_item(OP_ELEM, '0, 7'd3);
      send_item(OP_ELEM, '0, 7'd4);
      send_item(OP_ELEM, '0, 7'd127);
      send_item(OP_SPARE6, '1, '1);
      send_item(OP_SPARE7, '1, '1);
      send_item(OP_POP, '0, '0);
      send_item(OP_CLEAR, '0, '0);
      send_item(OP_TOP, '0, '0);
      send_item(OP_PUSH, 32'h1234_5678, '0);
      send_item(OP_ELEM, '0, 7'd1);

      mode = MODE_FILL;
      seg_left = DEF_STACK_DEPTH + $urandom_range(4, 8);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == HOLD_OFF_AT) begin
            hold_off_req = 1'b1;
         end
         if (n == PAUSE_AT) begin
            req_valid <= 1'b0;
            do @(posedge clock); while (outstanding != 0);
         end
         if (n == RANDOM_ITEMS - QUIET_ITEMS) begin
            idling_on = 1'b0;
         end
         if (seg_left == 0) begin
            case ($urandom_range(0, 5))
               0: mode = MODE_FILL;
               1: mode = MODE_DRAIN;
               2: mode = MODE_READS;
               default: mode = MODE_MIX;
            endcase
            seg_left = (mode == MODE_FILL) ? DEF_STACK_DEPTH + $urandom_range(2, 8)
                                           : $urandom_range(20, 60);
            case ($urandom_range(0, 2))
               0: src_gap_pct = 0;
               1: src_gap_pct = 10;
               default: src_gap_pct = 30;
            endcase
         end
         seg_left--;
         op = pick_op(mode);
         send_item(op, pick_value(), pick_index(stack_level));
      end
      req_valid <= 1'b0;

      do @(posedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d items, %0d results checked, peak height %0d",
               items_sent, results_checked, peak_level);
      $display("overflow %0d, underflow %0d, bad index %0d, mismatches %0d",
               overflow_hits, underflow_hits, range_hits, mismatches);
      if (mismatches == 0) begin
         $display("[array_stack_with_flip_core] OK");
      end else begin
         $display("[array_stack_with_flip_core] ERROR");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/asf_pkg.sv
hw/rtl/array_stack_with_flip_core.sv
hw/rtl/asf_checker.sv
bench/asf_stack_check.sv
bench/tb_top.sv
